[rtl/core/fla_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants for the free-list fit allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int HEADER_BYTES = 24;
  localparam int PAGE_BYTES   = 4096;
  localparam int MAX_EXTENTS  = 64;
  localparam int MAX_BLOCKS   = 64;
  localparam int REGION_CAP   = 1048576;

  localparam int SZ_W  = 21;
  localparam int EX_AW = $clog2(MAX_EXTENTS);
  localparam int BK_AW = $clog2(MAX_BLOCKS);
  localparam int EX_CW = EX_AW + 1;
  localparam int PG_SH = $clog2(PAGE_BYTES);

  localparam logic [SZ_W-1:0] HDR = SZ_W'(HEADER_BYTES);
  localparam logic [SZ_W-1:0] CAP_ROUND = SZ_W'((REGION_CAP / PAGE_BYTES) * PAGE_BYTES);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARGS = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_BAD_PTR  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_A_RD,
    S_A_CHK,
    S_A_SLOT,
    S_A_APPLY,
    S_F_BK_RD,
    S_F_BK_CHK,
    S_F_POS_RD,
    S_F_POS_CHK,
    S_F_PREV_RD,
    S_F_PREV_CHK,
    S_F_APPLY,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/fla_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/free_list_fit_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// free_list_fit_allocator_core
// Free-list allocator: first/best/worst fit, split and coalescing free.
// ----------------------------------------------------------------------------
// Steps from accept to done strobe: alloc reads free-table entries,
//   passes occupied block slots, applies the pick, and shifts entries down
//   on a whole-extent take; free probes block entries, walks extents to the
//   insert point, merges, and shifts entries to close or open a gap.
//   Commands rejected at accept go straight to the done state.
// Throughput: one command at a time; busy stays high until the done cycle.
// Reset and every config transfer pass through the init state, which clears
//   block_live. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module free_list_fit_allocator_core
  import fla_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            cmd,
  input  wire logic [SZ_W-1:0] req_bytes,
  input  wire logic [1:0]      fit_policy,
  input  wire logic [SZ_W-1:0] free_offset,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [SZ_W-1:0] cfg_data,
  output logic                 done,
  output logic [1:0]           status,
  output logic [SZ_W-1:0]      payload_offset
);

  state_t state, state_next;

  // Registers
  logic [SZ_W-1:0]   arena;
  logic [EX_CW-1:0]  ext_count;
  logic [MAX_BLOCKS-1:0] block_live;
  logic [EX_CW-1:0]  idx;        // walking index over extents
  logic [BK_AW:0]    bidx;       // walking index over blocks
  logic [SZ_W:0]     need;       // one bit wider: rounding can carry out
  logic [1:0]        pol;
  logic              found;
  logic [EX_AW-1:0]  pick;
  logic [SZ_W-1:0]   best;
  logic [SZ_W-1:0]   bs;         // block start being freed
  logic [SZ_W-1:0]   bb;         // its size
  logic [BK_AW-1:0]  slot;
  logic [SZ_W-1:0]   prev_end;   // start+bytes+header of pos-1
  logic [SZ_W-1:0]   pos_start;
  logic [SZ_W-1:0]   pos_bytes;
  logic              sh_up;      // shift direction: 1 opens a gap, 0 closes
  logic [EX_CW-1:0]  sh_end;
  logic [1:0]        res_st;
  logic [SZ_W-1:0]   res_off;
  logic              ins_pending;

  // The alloc apply reuses the free "prev" stages as a plain read of pick;
  // a flag tells them apart.
  logic is_alloc;
  logic join_prev, join_next;
  logic split_ok;

  // Extent RAM: {start, bytes}
  logic                   ex_we;
  logic [EX_AW-1:0]       ex_wa, ex_ra;
  logic [2*SZ_W-1:0]      ex_wd, ex_rd;
  logic [SZ_W-1:0]        ex_rs, ex_rb;
  // Block RAM: {start, bytes}
  logic                   bk_we;
  logic [BK_AW-1:0]       bk_wa, bk_ra;
  logic [2*SZ_W-1:0]      bk_wd, bk_rd;

  assign ex_rs = ex_rd[2*SZ_W-1:SZ_W];
  assign ex_rb = ex_rd[SZ_W-1:0];

  fla_ram #(.WIDTH(2*SZ_W), .DEPTH(MAX_EXTENTS)) u_ext (
    .clk(clk), .we(ex_we), .waddr(ex_wa), .wdata(ex_wd), .raddr(ex_ra), .rdata(ex_rd));
  fla_ram #(.WIDTH(2*SZ_W), .DEPTH(MAX_BLOCKS)) u_blk (
    .clk(clk), .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // Rounded arena size for a config write
  logic [SZ_W:0] cfg_round;
  logic [SZ_W-1:0] cfg_arena;
  always_comb begin
    cfg_round = ({1'b0, cfg_data} + (SZ_W+1)'(PAGE_BYTES - 1)) >> PG_SH << PG_SH;
    if (cfg_round == '0) begin
      cfg_arena = SZ_W'(PAGE_BYTES);
    end else if (cfg_round > (SZ_W+1)'(REGION_CAP)) begin
      cfg_arena = CAP_ROUND;
    end else begin
      cfg_arena = cfg_round[SZ_W-1:0];
    end
  end

  // Shared comparator / adder terms
  logic [SZ_W+1:0] blk_end;   // bs + bb + header
  logic [SZ_W+1:0] cur_end;   // ex_rs + ex_rb + header
  assign blk_end = {2'b0, bs} + {2'b0, bb} + {2'b0, HDR};
  assign cur_end = {2'b0, ex_rs} + {2'b0, ex_rb} + {2'b0, HDR};

  // picked extent keeps a remainder after the split
  assign split_ok = {1'b0, pos_bytes} > need + {1'b0, HDR};

  logic [EX_AW-1:0] idx_a;
  assign idx_a = idx[EX_AW-1:0];
  logic [BK_AW-1:0] bidx_a;
  assign bidx_a = bidx[BK_AW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (!cmd) begin
            if (req_bytes == '0 || fit_policy == 2'd3) state_next = S_DONE;
            else state_next = S_A_RD;
          end else begin
            if (free_offset == '0 || free_offset < HDR ||
                (free_offset - HDR) >= arena) state_next = S_DONE;
            else state_next = S_F_BK_RD;
          end
        end else if (cfg_valid) begin
          state_next = S_INIT;
        end
      end
      S_INIT:    state_next = S_IDLE;
      S_A_RD:    state_next = (idx >= ext_count) ? S_A_SLOT : S_A_CHK;
      S_A_CHK: begin
        if (pol == POL_FIRST && {1'b0, ex_rb} >= need) state_next = S_A_SLOT;
        else state_next = S_A_RD;
      end
      S_A_SLOT: begin
        if (!found) state_next = S_DONE;
        else if (bidx == (BK_AW+1)'(MAX_BLOCKS)) state_next = S_DONE;
        else if (!block_live[bidx_a]) state_next = S_A_APPLY;
      end
      S_A_APPLY: state_next = S_F_PREV_RD; // reread picked entry (reuse read stage)
      S_F_BK_RD: state_next = (bidx == (BK_AW+1)'(MAX_BLOCKS)) ? S_DONE : S_F_BK_CHK;
      S_F_BK_CHK: begin
        if (block_live[bidx_a] && bk_rd[2*SZ_W-1:SZ_W] == bs) state_next = S_F_POS_RD;
        else state_next = S_F_BK_RD;
      end
      S_F_POS_RD: state_next = (idx >= ext_count) ? S_F_PREV_RD : S_F_POS_CHK;
      S_F_POS_CHK: state_next = (ex_rs < bs) ? S_F_POS_RD : S_F_PREV_RD;
      S_F_PREV_RD: state_next = S_F_PREV_CHK;
      S_F_PREV_CHK: state_next = S_F_APPLY;
      S_F_APPLY: begin
        // shift setup lands at this edge, so decide from current values
        state_next = S_DONE;
        if (res_st == ST_OK) begin
          if (is_alloc) begin
            if (!split_ok && ({1'b0, pick} + 1'b1 < ext_count)) state_next = S_SH_RD;
          end else if (join_prev && join_next) begin
            if (idx + 1'b1 < ext_count) state_next = S_SH_RD;
          end else if (!join_prev && !join_next &&
                       ext_count < EX_CW'(MAX_EXTENTS) && ext_count > idx) begin
            state_next = S_SH_RD;
          end
        end
      end
      S_SH_RD:   state_next = S_SH_WR;
      S_SH_WR: begin
        if (sh_up ? (sh_end - 1'b1 > idx) : (idx + 2'd2 < sh_end)) state_next = S_SH_RD;
        else state_next = S_DONE;
      end
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    ex_we = 1'b0;
    ex_wa = idx_a;
    ex_wd = '0;
    ex_ra = idx_a;
    bk_we = 1'b0;
    bk_wa = slot;
    bk_wd = {bs, bb};
    bk_ra = bidx_a;
    unique case (state)
      S_INIT: begin
        ex_we = 1'b1;
        ex_wa = '0;
        ex_wd = {{SZ_W{1'b0}}, arena - HDR};
      end
      S_F_PREV_RD: begin
        ex_ra = is_alloc ? pick : (idx_a - 1'b1);
      end
      S_F_APPLY: begin
        if (res_st == ST_OK) begin
          if (is_alloc) begin
            bk_we = 1'b1;
            if (split_ok) begin
              bk_wd = {pos_start, need[SZ_W-1:0]};
              ex_we = 1'b1;
              ex_wa = pick;
              ex_wd = {pos_start + need[SZ_W-1:0] + HDR,
                       pos_bytes - need[SZ_W-1:0] - HDR};
            end else begin
              bk_wd = {pos_start, pos_bytes};
            end
          end else if (join_prev && join_next) begin
            ex_we = 1'b1;
            ex_wa = idx_a - 1'b1;
            ex_wd = {prev_end - best - HDR, best + bb + HDR + pos_bytes + HDR};
          end else if (join_next) begin
            ex_we = 1'b1;
            ex_wa = idx_a;
            ex_wd = {bs, pos_bytes + bb + HDR};
          end else if (join_prev) begin
            ex_we = 1'b1;
            ex_wa = idx_a - 1'b1;
            ex_wd = {prev_end - best - HDR, best + bb + HDR};
          end
        end
      end
      S_SH_RD: begin
        ex_ra = sh_up ? (sh_end[EX_AW-1:0] - 1'b1) : (idx_a + 1'b1);
      end
      S_SH_WR: begin
        ex_we = 1'b1;
        ex_wa = sh_up ? sh_end[EX_AW-1:0] : idx_a;
        ex_wd = ex_rd;
      end
      S_DONE: begin
        // new extent goes into the gap opened at idx
        if (ins_pending) begin
          ex_we = 1'b1;
          ex_wd = {bs, bb};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      arena      <= SZ_W'(REGION_CAP);
      ext_count  <= EX_CW'(1);
      block_live <= '0;
      done       <= 1'b0;
      ins_pending <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          idx      <= '0;
          bidx     <= '0;
          found    <= 1'b0;
          pick     <= '0;
          best     <= '0;
          need     <= ({1'b0, req_bytes} + (SZ_W+1)'(7)) & ~(SZ_W+1)'(7);
          pol      <= fit_policy;
          is_alloc <= !cmd;
          bs       <= free_offset - HDR;
          res_st   <= ST_OK;
          res_off  <= '0;
          sh_up    <= 1'b0;
          ins_pending <= 1'b0;
          if (start) begin
            if (!cmd && (req_bytes == '0 || fit_policy == 2'd3)) res_st <= ST_BAD_ARGS;
            if (cmd && free_offset != '0 && (free_offset < HDR ||
                (free_offset - HDR) >= arena)) res_st <= ST_BAD_PTR;
          end else if (cfg_valid) begin
            arena       <= cfg_arena;
          end
        end
        S_INIT: begin
          ext_count  <= EX_CW'(1);
          block_live <= '0;
        end
        S_A_CHK: begin
          idx <= idx + 1'b1;
          if ({1'b0, ex_rb} >= need) begin
            if (!found || (pol == POL_BEST && ex_rb < best) ||
                (pol == POL_WORST && ex_rb > best)) begin
              pick  <= idx_a;
              best  <= ex_rb;
              found <= 1'b1;
            end
          end
        end
        S_A_SLOT: begin
          if (!found || bidx == (BK_AW+1)'(MAX_BLOCKS)) begin
            res_st <= ST_NO_SPACE;
          end else if (!block_live[bidx_a]) begin
            slot <= bidx_a;
          end else begin
            bidx <= bidx + 1'b1;
          end
        end
        S_F_BK_RD: begin
          if (bidx == (BK_AW+1)'(MAX_BLOCKS)) res_st <= ST_BAD_PTR;
        end
        S_F_BK_CHK: begin
          slot <= bidx_a;
          bb   <= bk_rd[SZ_W-1:0];
          if (!(block_live[bidx_a] && bk_rd[2*SZ_W-1:SZ_W] == bs)) bidx <= bidx + 1'b1;
        end
        S_F_POS_CHK: begin
          if (ex_rs < bs) idx <= idx + 1'b1;
          pos_start <= ex_rs;
          pos_bytes <= ex_rb;
        end
        S_F_PREV_CHK: begin
          if (is_alloc) begin
            pos_start <= ex_rs;
            pos_bytes <= ex_rb;
            res_off   <= ex_rs + HDR;
          end else begin
            prev_end <= cur_end[SZ_W-1:0];
            best     <= ex_rb;
          end
        end
        S_F_APPLY: begin
          if (res_st == ST_OK) begin
            if (is_alloc) begin
              block_live[slot] <= 1'b1;
              if (!split_ok) begin
                idx    <= {1'b0, pick};
                sh_up  <= 1'b0;
                sh_end <= ext_count;
                ext_count <= ext_count - 1'b1;
              end
            end else if (join_prev && join_next) begin
              block_live[slot] <= 1'b0;
              sh_up  <= 1'b0;
              sh_end <= ext_count;
              ext_count <= ext_count - 1'b1;
            end else if (join_next || join_prev) begin
              block_live[slot] <= 1'b0;
              sh_end <= '0;
            end else if (ext_count >= EX_CW'(MAX_EXTENTS)) begin
              res_st <= ST_NO_SPACE;
            end else begin
              block_live[slot] <= 1'b0;
              sh_up  <= 1'b1;
              sh_end <= ext_count;
              ext_count <= ext_count + 1'b1;
              ins_pending <= 1'b1;
            end
          end
        end
        S_SH_WR: begin
          if (sh_up) sh_end <= sh_end - 1'b1;
          else idx <= idx + 1'b1;
        end
        S_DONE: begin
          done <= 1'b1;
          ins_pending <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // join flags from registered neighbor data (pos entry valid if idx<count)
  always_comb begin
    join_next = (idx < ext_count) && (blk_end == {2'b0, pos_start});
    join_prev = (idx != '0) && (prev_end == bs);
  end

  // Outputs from the result registers
  assign status         = res_st;
  assign payload_offset = (res_st == ST_OK && is_alloc) ? res_off : '0;

  // Assertions
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without work");
  a_count: assert property (@(posedge clk) disable iff (rst)
    ext_count <= EX_CW'(MAX_EXTENTS)) else $error("extent count overflow");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> state == S_INIT) else $error("config not applied");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the free-list fit allocator. A behavioral model of
// the free-extent and block tables predicts status and payload offset for
// each accepted command; a monitor compares every done strobe against the
// oldest prediction. Directed cases hit the corners, then random alloc/free
// traffic runs over several arena sizes.
// ----------------------------------------------------------------------------
module tb_top
  import fla_pkg::*;
;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic [1:0] POL_BAD = 2'd3;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    status_t         st;
    logic [SZ_W-1:0] off;
  } alloc_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  logic            cmd = CMD_ALLOC;
  logic [SZ_W-1:0] req_bytes = '0;
  logic [1:0]      fit_policy = 2'd0;
  logic [SZ_W-1:0] free_offset = '0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [SZ_W-1:0] cfg_data = '0;
  logic            done;
  logic [1:0]      status;
  logic [SZ_W-1:0] payload_offset;

  free_list_fit_allocator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .req_bytes(req_bytes), .fit_policy(fit_policy), .free_offset(free_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .payload_offset(payload_offset)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Allocator shadow: free extents in address order plus the block table.
  // --------------------------------------------------------------------------
  int unsigned arena_sz;
  int unsigned ext_start [MAX_EXTENTS];
  int unsigned ext_size  [MAX_EXTENTS];
  int unsigned ext_cnt;
  int unsigned blk_start [MAX_BLOCKS];
  int unsigned blk_size  [MAX_BLOCKS];
  bit          blk_live  [MAX_BLOCKS];

  alloc_result_t pending_q[$];
  int errors = 0;
  int burst_left = 0;

  function automatic void arena_init(logic [SZ_W-1:0] rs);
    int unsigned pages;
    pages = (int'(rs) + PAGE_BYTES - 1) / PAGE_BYTES;
    if (pages == 0) pages = 1;
    arena_sz = pages * PAGE_BYTES;
    if (arena_sz > REGION_CAP) arena_sz = (REGION_CAP / PAGE_BYTES) * PAGE_BYTES;
    for (int i = 0; i < MAX_BLOCKS; i++) blk_live[i] = 0;
    ext_start[0] = 0;
    ext_size[0]  = arena_sz - HEADER_BYTES;
    ext_cnt = 1;
  endfunction

  function automatic void ext_remove(int unsigned pos);
    for (int unsigned i = pos; i + 1 < ext_cnt; i++) begin
      ext_start[i] = ext_start[i+1];
      ext_size[i]  = ext_size[i+1];
    end
    ext_cnt--;
  endfunction

  function automatic status_t alloc_model(int unsigned req, logic [1:0] pol,
                                          output int unsigned off);
    int unsigned need, pick, best, slot;
    bit found, have_slot;
    found = 0; have_slot = 0; pick = 0; best = 0; slot = 0; off = 0;
    if (req == 0 || pol == POL_BAD) return ST_BAD_ARGS;
    need = (req + 7) & ~32'd7;
    for (int unsigned i = 0; i < ext_cnt; i++) begin
      if (ext_size[i] < need) continue;
      if (pol == POL_FIRST) begin
        pick = i; found = 1;
        break;
      end
      // strict compare keeps the lowest address on equal sizes
      if (!found || (pol == POL_BEST && ext_size[i] < best) ||
          (pol == POL_WORST && ext_size[i] > best)) begin
        pick = i; best = ext_size[i]; found = 1;
      end
    end
    if (!found) return ST_NO_SPACE;
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (!blk_live[i]) begin
        slot = i; have_slot = 1;
        break;
      end
    if (!have_slot) return ST_NO_SPACE;
    blk_start[slot] = ext_start[pick];
    blk_live[slot]  = 1;
    if (ext_size[pick] > need + HEADER_BYTES) begin
      blk_size[slot] = need;
      ext_start[pick] += need + HEADER_BYTES;
      ext_size[pick]  -= need + HEADER_BYTES;
    end else begin
      blk_size[slot] = ext_size[pick];
      ext_remove(pick);
    end
    off = blk_start[slot] + HEADER_BYTES;
    return ST_OK;
  endfunction

  // Where a released block would land and which neighbors it touches.
  function automatic void merge_probe(int unsigned bs, int unsigned bb,
                                      output int unsigned pos,
                                      output bit jn, output bit jp);
    pos = 0;
    while (pos < ext_cnt && ext_start[pos] < bs) pos++;
    jn = pos < ext_cnt && bs + bb + HEADER_BYTES == ext_start[pos];
    jp = pos > 0 && ext_start[pos-1] + ext_size[pos-1] + HEADER_BYTES == bs;
  endfunction

  function automatic status_t free_model(int unsigned off);
    int unsigned bs, bb, slot, pos;
    bit hit, jn, jp;
    hit = 0; slot = 0;
    if (off == 0) return ST_OK;
    if (off < HEADER_BYTES) return ST_BAD_PTR;
    bs = off - HEADER_BYTES;
    if (bs >= arena_sz) return ST_BAD_PTR;
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (blk_live[i] && blk_start[i] == bs) begin
        slot = i; hit = 1;
        break;
      end
    if (!hit) return ST_BAD_PTR;
    bb = blk_size[slot];
    merge_probe(bs, bb, pos, jn, jp);
    if (jp && jn) begin
      ext_size[pos-1] += bb + HEADER_BYTES + ext_size[pos] + HEADER_BYTES;
      ext_remove(pos);
    end else if (jn) begin
      ext_size[pos] += bb + HEADER_BYTES;
      ext_start[pos] = bs;
    end else if (jp) begin
      ext_size[pos-1] += bb + HEADER_BYTES;
    end else begin
      if (ext_cnt >= MAX_EXTENTS) return ST_NO_SPACE;  // block stays live
      for (int unsigned i = ext_cnt; i > pos; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_size[i]  = ext_size[i-1];
      end
      ext_start[pos] = bs;
      ext_size[pos]  = bb;
      ext_cnt++;
    end
    blk_live[slot] = 0;
    return ST_OK;
  endfunction

  function automatic int live_count();
    int n = 0;
    for (int i = 0; i < MAX_BLOCKS; i++) n += blk_live[i];
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Command sender: one transfer per call, bursts with random gaps between.
  // --------------------------------------------------------------------------
  task automatic send_cmd(logic c, logic [SZ_W-1:0] rq, logic [1:0] pol,
                          logic [SZ_W-1:0] fo);
    alloc_result_t r;
    int unsigned o;
    start <= 1'b1;
    cmd <= c;
    req_bytes <= rq;
    fit_policy <= pol;
    free_offset <= fo;
    do @(posedge clk); while (busy);
    // transfer taken at this edge
    o = 0;
    if (c == CMD_ALLOC) r.st = alloc_model(rq, pol, o);
    else r.st = free_model(fo);
    r.off = (r.st == ST_OK) ? o[SZ_W-1:0] : '0;
    pending_q.push_back(r);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_alloc(int unsigned rq, logic [1:0] pol);
    send_cmd(CMD_ALLOC, rq[SZ_W-1:0], pol, SZ_W'($urandom));
  endtask

  task automatic send_free(int unsigned fo);
    send_cmd(CMD_FREE, SZ_W'($urandom), 2'($urandom), fo[SZ_W-1:0]);
  endtask

  // Wait until every prediction is matched, then let trailing work settle.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_region(logic [SZ_W-1:0] rs);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= rs;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arena_init(rs);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: done is a one-cycle strobe, no backpressure possible.
  // --------------------------------------------------------------------------
  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result st=%0d off=%0d", status, payload_offset));
      end else begin
        e = pending_q.pop_front();
        if (status !== e.st)
          report($sformatf("status %0d, want %0d", status, e.st));
        if (payload_offset !== e.off)
          report($sformatf("payload_offset %0d, want %0d", payload_offset, e.off));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corners();
    send_alloc(0, POL_FIRST);                   // zero request
    send_alloc(1, POL_BAD);                     // invalid policy
    send_alloc(REGION_CAP, POL_FIRST);          // larger than any extent
    send_alloc(21'h1FFFFF, POL_WORST);          // all request bits set
    send_alloc(REGION_CAP - HEADER_BYTES, POL_BEST);  // exact fit, whole take
    send_alloc(8, POL_FIRST);                   // arena now empty
    send_free(HEADER_BYTES);
    send_free(HEADER_BYTES);                    // already released
    send_alloc(100, POL_FIRST);
    send_alloc(200, POL_BEST);
    send_alloc(300, POL_WORST);
    send_free(0);                               // null release
    send_free(5);                               // below header
    send_free(21'h1FFFFF);                      // past arena end
    send_free(4096);                            // never handed out
    send_free(HEADER_BYTES + 104 + HEADER_BYTES);     // middle block
    send_free(HEADER_BYTES);                    // merges with next
    send_free(HEADER_BYTES + 2*128 + 2*HEADER_BYTES); // inside a free extent, not a block
  endtask

  task automatic test_fit_policies();
    int unsigned sizes[6] = '{64, 8, 32, 8, 32, 8};
    int unsigned offs[6];
    set_region(21'd8192);
    foreach (sizes[i]) begin
      offs[i] = (i == 0) ? HEADER_BYTES : offs[i-1] + sizes[i-1] + HEADER_BYTES;
      send_alloc(sizes[i], POL_FIRST);
    end
    // holes of 64, 32 and 32: best fit tie picks the lower one
    send_free(offs[0]);
    send_free(offs[2]);
    send_free(offs[4]);
    send_alloc(24, POL_BEST);
    send_alloc(24, POL_WORST);
    send_alloc(24, POL_FIRST);
    send_alloc(32, POL_BEST);
  endtask

  // Fill the block table, then push the free-extent table to its limit.
  task automatic test_tables_full();
    int unsigned fresh[$];
    int unsigned o, pos;
    bit jn, jp;
    set_region(21'd1048576);
    for (int rounds = 0; rounds < 8 && ext_cnt < MAX_EXTENTS; rounds++) begin
      fresh.delete();
      while (live_count() < MAX_BLOCKS) begin
        o = 0;
        for (int i = 0; i < ext_cnt; i++)
          if (ext_size[i] > o) o = ext_start[i] + HEADER_BYTES;
        fresh.push_back(o);  // worst fit always carves the tail
        send_alloc(8, POL_WORST);
      end
      if (rounds == 0) send_alloc(8, POL_FIRST);   // block table full
      for (int i = 0; i + 1 < fresh.size(); i += 2) send_free(fresh[i]);
    end
    // release a block with live blocks on both sides while extents are full
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (blk_live[i]) begin
        merge_probe(blk_start[i], blk_size[i], pos, jn, jp);
        if (!jn && !jp) begin
          send_free(blk_start[i] + HEADER_BYTES);
          break;
        end
      end
  endtask

  task automatic test_random(int n);
    int unsigned live_offs[$];
    int unsigned sz, pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 19))
          0:       sz = $urandom_range(1, arena_sz);
          1:       sz = $urandom & 21'h1FFFFF;
          2, 3:    sz = $urandom_range(1, 8192);
          default: sz = $urandom_range(1, 256);
        endcase
        send_alloc(sz, 2'($urandom_range(0, 2)));
      end else if (pick < 88 && live_count() > 0) begin
        live_offs.delete();
        for (int i = 0; i < MAX_BLOCKS; i++)
          if (blk_live[i]) live_offs.push_back(blk_start[i] + HEADER_BYTES);
        send_free(live_offs[$urandom_range(0, live_offs.size() - 1)]);
      end else begin
        // noise: bad arguments and stray pointers
        case ($urandom_range(0, 4))
          0: send_alloc(0, 2'($urandom));
          1: send_alloc($urandom_range(1, 64), POL_BAD);
          2: send_free($urandom & 21'h1FFFFF);
          3: send_free($urandom_range(0, HEADER_BYTES + 64));
          default: send_free(0);
        endcase
      end
    end
  endtask

  initial begin
    arena_init(21'd1048576);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_corners();
    test_random(300);
    test_fit_policies();
    test_tables_full();
    set_region(21'd4096);                       // smallest arena
    test_random(300);
    set_region(21'd0);                          // zero rounds to one page
    test_random(150);
    set_region(21'h1FFFFF);                     // clamped
    test_random(300);
    set_region(SZ_W'($urandom_range(4097, 1048575)));
    test_random(300);
    set_region(21'd1048576);
    test_random(300);
    drain();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fla_pkg.sv
rtl/core/fla_ram.sv
rtl/core/free_list_fit_allocator_core.sv
sim/tb_top.sv
